// File: hdl/ewps_pkg.sv
// Shared types, register indexes and constants of the e-ink window page sequencer.
package ewps_pkg;

   // Panel and page geometry defaults
   localparam int PanelWidthDefault  = 128;
   localparam int PanelHeightDefault = 296;
   localparam int PageRowsDefault    = 16;

   // Saturation limits
   localparam logic [10:0] ROW_MAX   = 11'd2047;
   localparam logic [15:0] BYTES_MAX = 16'd65535;

   // Configuration register indexes
   localparam logic [3:0] CSR_WIN_LEFT    = 4'd0;
   localparam logic [3:0] CSR_WIN_TOP     = 4'd1;
   localparam logic [3:0] CSR_WIN_WIDTH   = 4'd2;
   localparam logic [3:0] CSR_WIN_HEIGHT  = 4'd3;
   localparam logic [3:0] CSR_FULL_SCREEN = 4'd4;
   localparam logic [3:0] CSR_ROTATION    = 4'd5;
   localparam logic [3:0] CSR_FLIP        = 4'd6;
   localparam logic [3:0] CSR_FAST_MODE   = 4'd7;

   // Fast update modes (code 3 acts as finalize)
   localparam logic [1:0] MODE_OFF      = 2'd0;
   localparam logic [1:0] MODE_ON       = 2'd1;
   localparam logic [1:0] MODE_FINALIZE = 2'd2;

   // Quarter turns of the drawing orientation
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef struct packed {
      logic [9:0]  win_left;
      logic [9:0]  win_top;
      logic [10:0] win_width;
      logic [10:0] win_height;
      logic        use_full_screen;
      logic [1:0]  rotation;
      logic [1:0]  flip;
      logic [1:0]  fast_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      win_left:        10'd0,
      win_top:         10'd0,
      win_width:       11'd128,
      win_height:      11'd296,
      use_full_screen: 1'b1,
      rotation:        ROT_0,
      flip:            2'd0,
      fast_mode:       MODE_OFF
   };

   // Byte-aligned window in panel coordinates
   typedef struct packed {
      logic [9:0]  rot_left;
      logic [9:0]  rot_right;
      logic [10:0] rot_top;
      logic [10:0] rot_bottom;
   } window_type;

endpackage

// File: hdl/ewps_window.sv
// Window unit: clamps, mirrors and rotates the configured window into panel coordinates.
module ewps_window #(
   parameter int PANEL_WIDTH  = ewps_pkg::PanelWidthDefault,
   parameter int PANEL_HEIGHT = ewps_pkg::PanelHeightDefault
) (
   input  logic                   clock,
   input  ewps_pkg::cfg_type      cfg,
   output ewps_pkg::window_type   window
);

   localparam logic [9:0]  PW_LAST    = 10'(PANEL_WIDTH - 1);
   localparam logic [9:0]  PH_LAST    = 10'(PANEL_HEIGHT - 1);
   localparam logic [10:0] PH_LAST_11 = 11'(PANEL_HEIGHT - 1);

   logic [9:0]  lim_x;
   logic [9:0]  lim_y;
   logic [9:0]  src_l;
   logic [9:0]  src_t;
   logic [10:0] src_w;
   logic [10:0] src_h;
   logic [11:0] sum_r;
   logic [11:0] sum_b;
   logic [9:0]  clp_l;
   logic [9:0]  clp_t;
   logic [9:0]  clp_r;
   logic [9:0]  clp_b;
   logic [9:0]  fl_l;
   logic [9:0]  fl_t;
   logic [9:0]  fl_r;
   logic [9:0]  fl_b;
   logic [9:0]  col_a;
   logic [9:0]  col_c;
   ewps_pkg::window_type window_in;
   ewps_pkg::window_type window_ff;

   // Pick the source rectangle and clamp it to the panel
   always_comb begin
      lim_x = cfg.rotation[0] ? PH_LAST : PW_LAST;
      lim_y = cfg.rotation[0] ? PW_LAST : PH_LAST;
      if (cfg.use_full_screen) begin
         src_l = '0;
         src_t = '0;
         src_w = {1'b0, lim_x} + 11'd1;
         src_h = {1'b0, lim_y} + 11'd1;
      end else begin
         src_l = cfg.win_left;
         src_t = cfg.win_top;
         src_w = (cfg.win_width == '0) ? 11'd1 : cfg.win_width;
         src_h = (cfg.win_height == '0) ? 11'd1 : cfg.win_height;
      end
      sum_r = {2'b0, src_l} + {1'b0, src_w} - 12'd1;
      sum_b = {2'b0, src_t} + {1'b0, src_h} - 12'd1;
      clp_r = (sum_r > {2'b0, lim_x}) ? lim_x : sum_r[9:0];
      clp_b = (sum_b > {2'b0, lim_y}) ? lim_y : sum_b[9:0];
      clp_l = (src_l > lim_x) ? lim_x : src_l;
      clp_t = (src_t > lim_y) ? lim_y : src_t;
   end

   // Mirror horizontally and vertically
   always_comb begin
      fl_l = cfg.flip[0] ? (lim_x - clp_r) : clp_l;
      fl_r = cfg.flip[0] ? (lim_x - clp_l) : clp_r;
      fl_t = cfg.flip[1] ? (lim_y - clp_b) : clp_t;
      fl_b = cfg.flip[1] ? (lim_y - clp_t) : clp_b;
   end

   // Rotate into panel coordinates and widen columns to whole bytes
   always_comb begin
      col_a = fl_l;
      col_c = fl_r;
      window_in = '0;
      unique case (cfg.rotation)
         ewps_pkg::ROT_0: begin
            col_a = fl_l;
            col_c = fl_r;
            window_in.rot_top    = {1'b0, fl_t};
            window_in.rot_bottom = {1'b0, fl_b};
         end
         ewps_pkg::ROT_90: begin
            col_a = PW_LAST - fl_b;
            col_c = PW_LAST - fl_t;
            window_in.rot_top    = {1'b0, fl_l};
            window_in.rot_bottom = {1'b0, fl_r} + 11'd1;
         end
         ewps_pkg::ROT_180: begin
            col_a = PW_LAST - fl_r;
            col_c = PW_LAST - fl_l;
            window_in.rot_top    = PH_LAST_11 - {1'b0, fl_b};
            window_in.rot_bottom = PH_LAST_11 - {1'b0, fl_t};
         end
         ewps_pkg::ROT_270: begin
            col_a = fl_t;
            col_c = fl_b;
            window_in.rot_top    = PH_LAST_11 - {1'b0, fl_r};
            window_in.rot_bottom = PH_LAST_11 - {1'b0, fl_l};
         end
         default: begin
            col_a = fl_l;
            col_c = fl_r;
         end
      endcase
      window_in.rot_left  = {col_a[9:3], 3'b000};
      window_in.rot_right = {col_c[9:3], 3'b111};
   end

   // Hold the candidate window in a register behind the configuration registers
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign window = window_ff;

endmodule

// File: hdl/eink_window_page_sequencer.sv
// Top level of the e-ink window page sequencer: registers, pass control and result stage.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_step
//   rsp       out        rsp_valid/rsp_ready   rsp_keep_going .. rsp_byte_col_right
//   csr       in         csr_valid/csr_ready   csr_index, csr_data
//
// A step word is taken every cycle that ready is high, and its result word appears in the next cycle.
// A step of 0 is taken and yields no result word.
// After a register write the request side holds ready low for one cycle while
// the window unit recomputes its candidate window register.
// The result register stalls the request side only when it is full and not taken.
// Reset (synchronous, active high) restores register defaults and ends any pass.
module eink_window_page_sequencer #(
   parameter int PANEL_WIDTH  = ewps_pkg::PanelWidthDefault,
   parameter int PANEL_HEIGHT = ewps_pkg::PanelHeightDefault,
   parameter int PAGE_ROWS    = ewps_pkg::PageRowsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_step,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_keep_going,
   output logic        rsp_write_previous,
   output logic        rsp_refresh,
   output logic [10:0] rsp_page_first_row,
   output logic [10:0] rsp_page_last_row,
   output logic [15:0] rsp_page_bytes,
   output logic [9:0]  rsp_byte_col_left,
   output logic [9:0]  rsp_byte_col_right,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam logic [11:0] PR_STEP  = 12'(PAGE_ROWS);
   localparam logic [11:0] PR_M1    = 12'(PAGE_ROWS - 1);
   localparam logic [11:0] PR2_M1   = 12'(2 * PAGE_ROWS - 1);
   localparam logic [11:0] ROW_MAX_12 = {1'b0, ewps_pkg::ROW_MAX};

   ewps_pkg::cfg_type    cfg_ff;
   ewps_pkg::cfg_type    cfg_in;
   ewps_pkg::window_type win_cand;
   ewps_pkg::window_type rot_ff;
   ewps_pkg::window_type rot_use;

   logic        csr_take;
   logic        stale_ff;
   logic        req_take;
   logic        fire;
   logic        in_pass_ff;
   logic        in_pass_in;
   logic [10:0] band_top_ff;
   logic [10:0] band_top_in;
   logic [10:0] band_bottom_ff;
   logic [10:0] band_bottom_in;
   logic        first_of_two_ff;
   logic        first_of_two_in;
   logic        forced_off_ff;
   logic        forced_off_in;
   logic [11:0] sum_top;
   logic [11:0] sum_bot;
   logic [10:0] sat_bot;
   logic        wprev;
   logic        ended;
   logic [1:0]  mode;
   logic        keep;
   logic        refresh;
   logic [11:0] rows;
   logic [7:0]  width_bytes;
   logic [19:0] product;
   logic [15:0] bytes;

   logic        rsp_valid_ff;
   logic        rsp_keep_ff;
   logic        rsp_wprev_ff;
   logic        rsp_refresh_ff;
   logic [10:0] rsp_first_ff;
   logic [10:0] rsp_last_ff;
   logic [15:0] rsp_bytes_ff;
   logic [9:0]  rsp_left_ff;
   logic [9:0]  rsp_right_ff;

   ewps_window #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_window (
      .clock  (clock),
      .cfg    (cfg_ff),
      .window (win_cand)
   );

   // Handshakes
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign req_ready = (!rsp_valid_ff || rsp_ready) && !stale_ff;
   assign req_take  = req_valid && req_ready;
   assign fire      = req_take && req_step;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            ewps_pkg::CSR_WIN_LEFT:    cfg_in.win_left        = csr_data[9:0];
            ewps_pkg::CSR_WIN_TOP:     cfg_in.win_top         = csr_data[9:0];
            ewps_pkg::CSR_WIN_WIDTH:   cfg_in.win_width       = csr_data;
            ewps_pkg::CSR_WIN_HEIGHT:  cfg_in.win_height      = csr_data;
            ewps_pkg::CSR_FULL_SCREEN: cfg_in.use_full_screen = csr_data[0];
            ewps_pkg::CSR_ROTATION:    cfg_in.rotation        = csr_data[1:0];
            ewps_pkg::CSR_FLIP:        cfg_in.flip            = csr_data[1:0];
            ewps_pkg::CSR_FAST_MODE:   cfg_in.fast_mode       = csr_data[1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // Advance the band: latch the window on the first step of a pass
   always_comb begin
      rot_use = in_pass_ff ? rot_ff : win_cand;
      wprev   = 1'b0;
      if (!in_pass_ff) begin
         sum_top     = {1'b0, win_cand.rot_top};
         sum_bot     = {1'b0, win_cand.rot_top} + PR_M1;
         band_top_in = win_cand.rot_top;
         sat_bot     = (sum_bot > ROW_MAX_12) ? ewps_pkg::ROW_MAX : sum_bot[10:0];
         band_bottom_in = sat_bot;
      end else begin
         wprev = !((rot_ff.rot_bottom < band_top_ff) || (rot_ff.rot_top > band_bottom_ff));
         sum_top     = {1'b0, band_top_ff} + PR_STEP;
         sum_bot     = {1'b0, band_top_ff} + PR2_M1;
         band_top_in = (sum_top > ROW_MAX_12) ? ewps_pkg::ROW_MAX : sum_top[10:0];
         sat_bot     = (sum_bot > ROW_MAX_12) ? ewps_pkg::ROW_MAX : sum_bot[10:0];
         band_bottom_in = (sat_bot < rot_ff.rot_bottom) ? sat_bot : rot_ff.rot_bottom;
      end
   end

   // End of pass and fast mode handling
   always_comb begin
      ended           = band_top_in > rot_use.rot_bottom;
      mode            = forced_off_ff ? ewps_pkg::MODE_OFF : cfg_ff.fast_mode;
      keep            = 1'b1;
      refresh         = 1'b0;
      first_of_two_in = first_of_two_ff;
      forced_off_in   = forced_off_ff;
      in_pass_in      = !ended;
      if (ended) begin
         keep = 1'b0;
         if (mode == ewps_pkg::MODE_ON) begin
            refresh = 1'b1;
         end else if (mode >= ewps_pkg::MODE_FINALIZE) begin
            refresh = 1'b1;
            if (first_of_two_ff) begin
               first_of_two_in = 1'b0;
               keep            = 1'b1;
            end else begin
               first_of_two_in = 1'b1;
               forced_off_in   = 1'b1;
            end
         end
      end
   end

   // Band length in bytes, saturated
   always_comb begin
      rows        = {1'b0, band_bottom_in} - {1'b0, band_top_in} + 12'd1;
      width_bytes = {1'b0, rot_use.rot_right[9:3]} - {1'b0, rot_use.rot_left[9:3]} + 8'd1;
      product     = 20'(rows) * 20'(width_bytes);
      if (band_bottom_in < band_top_in) begin
         bytes = '0;
      end else if (product > 20'(ewps_pkg::BYTES_MAX)) begin
         bytes = ewps_pkg::BYTES_MAX;
      end else begin
         bytes = product[15:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= ewps_pkg::CFG_RESET;
         stale_ff        <= 1'b1;
         in_pass_ff      <= 1'b0;
         band_top_ff     <= '0;
         band_bottom_ff  <= '0;
         rot_ff          <= '0;
         first_of_two_ff <= 1'b1;
         forced_off_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         stale_ff <= csr_take;
         if (fire) begin
            in_pass_ff      <= in_pass_in;
            band_top_ff     <= band_top_in;
            band_bottom_ff  <= band_bottom_in;
            rot_ff          <= rot_use;
            first_of_two_ff <= first_of_two_in;
         end
         // a fast mode write releases the forced off state
         if (csr_take && (csr_index == ewps_pkg::CSR_FAST_MODE)) begin
            forced_off_ff <= 1'b0;
         end else if (fire) begin
            forced_off_ff <= forced_off_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_keep_ff    <= keep;
         rsp_wprev_ff   <= wprev;
         rsp_refresh_ff <= refresh;
         rsp_first_ff   <= band_top_in;
         rsp_last_ff    <= band_bottom_in;
         rsp_bytes_ff   <= bytes;
         rsp_left_ff    <= rot_use.rot_left;
         rsp_right_ff   <= rot_use.rot_right;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keep_going     = rsp_keep_ff;
   assign rsp_write_previous = rsp_wprev_ff;
   assign rsp_refresh        = rsp_refresh_ff;
   assign rsp_page_first_row = rsp_first_ff;
   assign rsp_page_last_row  = rsp_last_ff;
   assign rsp_page_bytes     = rsp_bytes_ff;
   assign rsp_byte_col_left  = rsp_left_ff;
   assign rsp_byte_col_right = rsp_right_ff;

   // Checks
   a_stale_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_take |=> !req_ready)
      else $error("step word accepted while the window was being recomputed");

   a_empty_band: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_last_ff < rsp_first_ff)) |-> (rsp_bytes_ff == '0))
      else $error("band past end reports nonzero bytes");

   a_byte_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_left_ff[2:0] == 3'b000) && (rsp_right_ff[2:0] == 3'b111)))
      else $error("window columns not byte aligned");

   a_forced_pair: assert property (@(posedge clock) disable iff (reset)
      forced_off_ff |-> first_of_two_ff)
      else $error("forced off without the finalize pair reset");

   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      (fire && ended) |=> !in_pass_ff)
      else $error("pass still running after its last step");

endmodule

// File: tb/eink_window_page_sequencer_test.sv
// Self-checking testbench of the e-ink window page sequencer with a page band scoreboard.
`timescale 1ns / 1ps

// One result word of the sequencer
typedef struct packed {
   logic        keep_going;
   logic        write_previous;
   logic        refresh;
   logic [10:0] first_row;
   logic [10:0] last_row;
   logic [15:0] byte_count;
   logic [9:0]  col_left;
   logic [9:0]  col_right;
} page_word_type;

// Tracks the pass state, predicts each page word and checks what the block returns
class page_band_tracker;
   localparam int unsigned COL_LAST = ewps_pkg::PanelWidthDefault - 1;
   localparam int unsigned ROW_LAST = ewps_pkg::PanelHeightDefault - 1;
   localparam int unsigned BAND_ROWS = ewps_pkg::PageRowsDefault;
   localparam int REPORT_LIMIT = 10;

   ewps_pkg::cfg_type     regs;
   ewps_pkg::window_type  win;
   bit            in_pass;
   bit            first_of_two;
   bit            forced_off;
   logic [10:0]   band_top;
   logic [10:0]   band_bottom;
   page_word_type pending_pages[$];
   int            mismatches;

   function new();
      regs = ewps_pkg::CFG_RESET;
      win = '0;
      in_pass = 1'b0;
      first_of_two = 1'b1;
      forced_off = 1'b0;
      band_top = '0;
      band_bottom = '0;
      mismatches = 0;
   endfunction

   static function int unsigned clamp_at(int unsigned v, int unsigned lim);
      return (v > lim) ? lim : v;
   endfunction

   function void write_reg(logic [3:0] index, logic [10:0] data);
      case (index)
         ewps_pkg::CSR_WIN_LEFT:    regs.win_left = data[9:0];
         ewps_pkg::CSR_WIN_TOP:     regs.win_top = data[9:0];
         ewps_pkg::CSR_WIN_WIDTH:   regs.win_width = data;
         ewps_pkg::CSR_WIN_HEIGHT:  regs.win_height = data;
         ewps_pkg::CSR_FULL_SCREEN: regs.use_full_screen = data[0];
         ewps_pkg::CSR_ROTATION:    regs.rotation = data[1:0];
         ewps_pkg::CSR_FLIP:        regs.flip = data[1:0];
         ewps_pkg::CSR_FAST_MODE: begin
            regs.fast_mode = data[1:0];
            forced_off = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Clamp, mirror and rotate the drawing window into byte-aligned panel coordinates
   function void latch_window();
      int unsigned lim_x, lim_y, l, t, w, h, r, b, a, c, swap;
      lim_x = regs.rotation[0] ? ROW_LAST : COL_LAST;
      lim_y = regs.rotation[0] ? COL_LAST : ROW_LAST;
      if (regs.use_full_screen) begin
         l = 0;
         t = 0;
         w = lim_x + 1;
         h = lim_y + 1;
      end else begin
         l = regs.win_left;
         t = regs.win_top;
         w = regs.win_width;
         h = regs.win_height;
      end
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      r = clamp_at(l + w - 1, lim_x);
      b = clamp_at(t + h - 1, lim_y);
      l = clamp_at(l, lim_x);
      t = clamp_at(t, lim_y);
      if (regs.flip[0]) begin
         swap = lim_x - r;
         r = lim_x - l;
         l = swap;
      end
      if (regs.flip[1]) begin
         swap = lim_y - b;
         b = lim_y - t;
         t = swap;
      end
      case (regs.rotation)
         ewps_pkg::ROT_0: begin
            a = l;
            c = r;
            win.rot_top = 11'(t);
            win.rot_bottom = 11'(b);
         end
         ewps_pkg::ROT_90: begin
            // rotated bottom lands one row past the window's right column
            a = COL_LAST - b;
            c = COL_LAST - t;
            win.rot_top = 11'(l);
            win.rot_bottom = 11'(r + 1);
         end
         ewps_pkg::ROT_180: begin
            a = COL_LAST - r;
            c = COL_LAST - l;
            win.rot_top = 11'(ROW_LAST - b);
            win.rot_bottom = 11'(ROW_LAST - t);
         end
         default: begin
            a = t;
            c = b;
            win.rot_top = 11'(ROW_LAST - r);
            win.rot_bottom = 11'(ROW_LAST - l);
         end
      endcase
      win.rot_left = 10'(a & ~32'd7);
      win.rot_right = 10'(c | 32'd7);
   endfunction

   // Advance the pass by one band for an accepted step word
   function void note_step(logic step);
      page_word_type page;
      int unsigned   next_bottom, rows, span, bytes;
      logic [1:0]    mode;
      if (!step) return;
      page = '0;
      if (!in_pass) begin
         latch_window();
         band_top = win.rot_top;
         band_bottom = 11'(clamp_at(win.rot_top + BAND_ROWS - 1, ewps_pkg::ROW_MAX));
      end else begin
         page.write_previous = !(win.rot_bottom < band_top || win.rot_top > band_bottom);
         band_top = 11'(clamp_at(band_top + BAND_ROWS, ewps_pkg::ROW_MAX));
         next_bottom = clamp_at(band_top + BAND_ROWS - 1, ewps_pkg::ROW_MAX);
         band_bottom = (next_bottom < win.rot_bottom) ? 11'(next_bottom) : win.rot_bottom;
      end

      // end of pass: refresh in fast modes, finalize runs a second pass then drops to off
      if (band_top > win.rot_bottom) begin
         in_pass = 1'b0;
         mode = forced_off ? ewps_pkg::MODE_OFF : regs.fast_mode;
         if (mode == ewps_pkg::MODE_ON) begin
            page.refresh = 1'b1;
         end else if (mode >= ewps_pkg::MODE_FINALIZE) begin
            page.refresh = 1'b1;
            if (first_of_two) begin
               first_of_two = 1'b0;
               page.keep_going = 1'b1;
            end else begin
               first_of_two = 1'b1;
               forced_off = 1'b1;
            end
         end
      end else begin
         in_pass = 1'b1;
         page.keep_going = 1'b1;
      end

      if (band_bottom < band_top) begin
         bytes = 0;
      end else begin
         rows = band_bottom - band_top + 1;
         span = win.rot_right - win.rot_left + 1;
         bytes = clamp_at(rows * (span >> 3), ewps_pkg::BYTES_MAX);
      end
      page.first_row = band_top;
      page.last_row = band_bottom;
      page.byte_count = 16'(bytes);
      page.col_left = win.rot_left;
      page.col_right = win.rot_right;
      pending_pages.push_back(page);
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("page word %s: expected %0d, got %0d", field, want, got);
      end
   endfunction

   function void check_page(page_word_type got);
      page_word_type want;
      if (pending_pages.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("page word with none expected: got %p", got);
         return;
      end
      want = pending_pages.pop_front();
      compare_field("keep_going", want.keep_going, got.keep_going);
      compare_field("write_previous", want.write_previous, got.write_previous);
      compare_field("refresh", want.refresh, got.refresh);
      compare_field("page_first_row", want.first_row, got.first_row);
      compare_field("page_last_row", want.last_row, got.last_row);
      compare_field("page_bytes", want.byte_count, got.byte_count);
      compare_field("byte_col_left", want.col_left, got.col_left);
      compare_field("byte_col_right", want.col_right, got.col_right);
   endfunction
endclass

module eink_window_page_sequencer_test;
   localparam int REG_COUNT = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int STEP_TARGET = 1750;
   localparam logic [3:0] CSR_SPARE_FIRST = ewps_pkg::CSR_FAST_MODE + 4'd1;
   // unnamed mode code, acts as finalize
   localparam logic [1:0] MODE_ALIAS = ewps_pkg::MODE_FINALIZE | ewps_pkg::MODE_ON;
   localparam logic [1:0] FLIP_NONE = 2'd0;
   localparam logic [1:0] FLIP_H = 2'd1;
   localparam logic [1:0] FLIP_V = 2'd2;

   typedef logic [10:0] reg_values_type [REG_COUNT];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_step = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_keep_going;
   logic        rsp_write_previous;
   logic        rsp_refresh;
   logic [10:0] rsp_page_first_row;
   logic [10:0] rsp_page_last_row;
   logic [15:0] rsp_page_bytes;
   logic [9:0]  rsp_byte_col_left;
   logic [9:0]  rsp_byte_col_right;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [10:0] csr_data = '0;

   page_band_tracker pages;
   bit calm = 1'b0;
   int hold_off = 0;
   int steps_done = 0;

   eink_window_page_sequencer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_step           (req_step),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keep_going     (rsp_keep_going),
      .rsp_write_previous (rsp_write_previous),
      .rsp_refresh        (rsp_refresh),
      .rsp_page_first_row (rsp_page_first_row),
      .rsp_page_last_row  (rsp_page_last_row),
      .rsp_page_bytes     (rsp_page_bytes),
      .rsp_byte_col_left  (rsp_byte_col_left),
      .rsp_byte_col_right (rsp_byte_col_right),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Take result words, pausing ready at random after each one unless calm is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_off = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pages.check_page('{rsp_keep_going, rsp_write_previous, rsp_refresh,
                               rsp_page_first_row, rsp_page_last_row, rsp_page_bytes,
                               rsp_byte_col_left, rsp_byte_col_right});
            hold_off = calm ? 0 : $urandom_range(0, 15);
         end
         if (hold_off != 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [3:0] index, logic [10:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      pages.write_reg(index, data);
   endtask

   // Write the selected registers back to back, optionally hitting a spare index
   task automatic program_regs(reg_values_type vals, logic [REG_COUNT-1:0] mask, bit stray);
      for (int i = 0; i < REG_COUNT; i++)
         if (mask[i]) write_reg(4'(i), vals[i]);
      if (stray)
         write_reg(CSR_SPARE_FIRST + 4'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)));
      csr_valid <= 1'b0;
   endtask

   // Send step words with random gaps; about one in ten is a no-op step
   task automatic send_steps(int count);
      int   gap;
      logic step;
      for (int n = 0; n < count; n++) begin
         step = ($urandom_range(0, 9) != 0);
         gap = calm ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_step <= step;
         do @(posedge clock); while (!req_ready);
         pages.note_step(step);
         steps_done++;
      end
      req_valid <= 1'b0;
   endtask

   // Hold the sender until every expected word is back and the block is quiet
   task automatic wait_drained();
      while (pages.pending_pages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reg_values_type vals;
      int             pick;
      pages = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // off-panel corner, zero size, landscape, both mirrors, mode three over three passes
      program_regs('{11'd1023, 11'd1023, 11'd0, 11'd0, 11'd0, 11'(ewps_pkg::ROT_90),
                     11'(FLIP_H | FLIP_V), 11'(MODE_ALIAS)}, '1, 1'b0);
      send_steps(7);
      wait_drained();

      // oversized width with all data bits set, one row, upside down, single fast pass
      program_regs('{11'd2047, 11'd0, 11'd2047, 11'd1, 11'd0, 11'(ewps_pkg::ROT_180),
                     11'(FLIP_H), 11'(ewps_pkg::MODE_ON)}, '1, 1'b0);
      send_steps(4);
      wait_drained();

      // narrow tall window in the other landscape, vertical mirror, finalize
      program_regs('{11'd37, 11'd200, 11'd9, 11'd1024, 11'd0, 11'(ewps_pkg::ROT_270),
                     11'(FLIP_V), 11'(ewps_pkg::MODE_FINALIZE)}, '1, 1'b0);
      send_steps(5);

      // random settings, each phase drained first so writes land with no result word outstanding
      while (steps_done < STEP_TARGET) begin
         wait_drained();
         calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < REG_COUNT; i++) begin
            pick = $urandom_range(0, 7);
            case (4'(i))
               ewps_pkg::CSR_WIN_LEFT, ewps_pkg::CSR_WIN_TOP:
                  vals[i] = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd1023 :
                            (pick == 2) ? 11'($urandom_range(0, 1023)) :
                            11'($urandom_range(0, 320));
               ewps_pkg::CSR_WIN_WIDTH, ewps_pkg::CSR_WIN_HEIGHT:
                  vals[i] = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd1024 :
                            (pick == 2) ? 11'($urandom_range(0, 2047)) :
                            11'($urandom_range(1, 64));
               ewps_pkg::CSR_FULL_SCREEN: vals[i] = 11'($urandom_range(0, 1));
               default: vals[i] = 11'($urandom_range(0, 3));
            endcase
            if ($urandom_range(0, 7) == 0) vals[i] = 11'($urandom_range(0, 2047));
         end
         program_regs(vals, REG_COUNT'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
         send_steps($urandom_range(1, 48));
      end

      wait_drained();
      if (pages.mismatches == 0) begin
         $display("eink_window_page_sequencer_test: done, clean");
      end else begin
         $display("eink_window_page_sequencer_test: done, errors");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("eink_window_page_sequencer_test: done, errors");
      $finish;
   end
endmodule

// File: filelist.f
hdl/ewps_pkg.sv
hdl/ewps_window.sv
hdl/eink_window_page_sequencer.sv
tb/eink_window_page_sequencer_test.sv
